>>> sv/jlp_pkg.sv
// Shared types and constants for the joystick line parser.
package jlp_pkg;

    localparam int unsigned LINE_CAPACITY = 49;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned MAG_W = 16;
    localparam int unsigned LIMIT_W = 15;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_X     = 8'h58;
    localparam logic [7:0] CHR_Y     = 8'h59;

    localparam logic [LIMIT_W-1:0] CLAMP_RESET = LIMIT_W'(100);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LEAD   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic               negative;
        logic [MAG_W-1:0]   magnitude;
    } num_state_t;

    typedef struct packed {
        logic               hit;
        logic               x_negative;
        logic [MAG_W-1:0]   x_magnitude;
        logic               y_negative;
        logic [MAG_W-1:0]   y_magnitude;
    } line_result_t;

    function automatic logic [MAG_W-1:0] clamp_axis(
        input logic               negative,
        input logic [MAG_W-1:0]   magnitude,
        input logic [LIMIT_W-1:0] limit
    );
        logic [MAG_W-1:0] lim_ext;
        logic [MAG_W-1:0] m;
        lim_ext = {1'b0, limit};
        m = (magnitude > lim_ext) ? lim_ext : magnitude;
        return negative ? (~m + MAG_W'(1)) : m;
    endfunction

endpackage

>>> sv/jlp_num_unit.sv
// Decimal number accumulator step: whitespace, sign, saturating digits.
module jlp_num_unit (
    input  logic [7:0]          rx_byte,
    input  jlp_pkg::num_state_t cur,
    output jlp_pkg::num_state_t nxt
);

    logic                        is_digit;
    logic                        is_blank;
    logic                        is_sign;
    logic [jlp_pkg::MAG_W+3:0]   acc;
    logic [jlp_pkg::MAG_W-1:0]   sat;

    assign is_digit = (rx_byte >= jlp_pkg::CHR_ZERO) && (rx_byte <= jlp_pkg::CHR_NINE);
    assign is_blank = (rx_byte == jlp_pkg::CHR_SPACE) ||
                      ((rx_byte >= jlp_pkg::CHR_TAB) && (rx_byte <= jlp_pkg::CHR_CR));
    assign is_sign  = (rx_byte == jlp_pkg::CHR_PLUS) || (rx_byte == jlp_pkg::CHR_MINUS);

    assign acc = ({4'b0, cur.magnitude} * (jlp_pkg::MAG_W + 4)'(10)) +
                 (jlp_pkg::MAG_W + 4)'(rx_byte - jlp_pkg::CHR_ZERO);
    assign sat = (acc[jlp_pkg::MAG_W+3:jlp_pkg::MAG_W] != 4'b0) ?
                 {jlp_pkg::MAG_W{1'b1}} : acc[jlp_pkg::MAG_W-1:0];

    always_comb begin
        nxt = cur;
        case (cur.phase)
            jlp_pkg::PH_LEAD: begin
                if (is_blank) begin
                    nxt = cur;
                end else if (is_sign) begin
                    nxt.negative = (rx_byte == jlp_pkg::CHR_MINUS);
                    nxt.phase    = jlp_pkg::PH_DIGITS;
                end else if (is_digit) begin
                    nxt.magnitude = sat;
                    nxt.phase     = jlp_pkg::PH_DIGITS;
                end else begin
                    nxt.phase = jlp_pkg::PH_DONE;
                end
            end
            jlp_pkg::PH_DIGITS: begin
                if (is_digit) begin
                    nxt.magnitude = sat;
                end else begin
                    nxt.phase = jlp_pkg::PH_DONE;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

>>> sv/jlp_line_core.sv
// Line state: byte count, marker and order flags, and both axis accumulators.
module jlp_line_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic [7:0]             rx_byte,
    output jlp_pkg::line_result_t  result
);

    localparam logic [jlp_pkg::COUNT_W-1:0] CAP =
        jlp_pkg::COUNT_W'(jlp_pkg::LINE_CAPACITY);
    localparam jlp_pkg::num_state_t NUM_CLEAR = '{
        phase: jlp_pkg::PH_IDLE, negative: 1'b0, magnitude: '0};

    logic [jlp_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]                  prev_reg, prev_next;
    logic                        ended_reg, ended_next;
    logic                        x_seen_reg, x_seen_next;
    logic                        comma_reg, comma_next;
    logic                        y_seen_reg, y_seen_next;
    logic                        fail_reg, fail_next;
    jlp_pkg::num_state_t         x_num_reg, x_num_next;
    jlp_pkg::num_state_t         y_num_reg, y_num_next;
    jlp_pkg::num_state_t         x_step, y_step;
    logic                        is_eol;

    jlp_num_unit u_x_num (
        .rx_byte (rx_byte),
        .cur     (x_num_reg),
        .nxt     (x_step)
    );

    jlp_num_unit u_y_num (
        .rx_byte (rx_byte),
        .cur     (y_num_reg),
        .nxt     (y_step)
    );

    assign is_eol = (rx_byte == jlp_pkg::CHR_LF) || (rx_byte == jlp_pkg::CHR_CR);

    assign result.hit         = step_en && is_eol && (count_reg != '0) &&
                                x_seen_reg && y_seen_reg && !fail_reg;
    assign result.x_negative  = x_num_reg.negative;
    assign result.x_magnitude = x_num_reg.magnitude;
    assign result.y_negative  = y_num_reg.negative;
    assign result.y_magnitude = y_num_reg.magnitude;

    always_comb begin
        count_next  = count_reg;
        prev_next   = prev_reg;
        ended_next  = ended_reg;
        x_seen_next = x_seen_reg;
        comma_next  = comma_reg;
        y_seen_next = y_seen_reg;
        fail_next   = fail_reg;
        x_num_next  = x_num_reg;
        y_num_next  = y_num_reg;
        if (is_eol) begin
            count_next  = '0;
            prev_next   = '0;
            ended_next  = 1'b0;
            x_seen_next = 1'b0;
            comma_next  = 1'b0;
            y_seen_next = 1'b0;
            fail_next   = 1'b0;
            x_num_next  = NUM_CLEAR;
            y_num_next  = NUM_CLEAR;
        end else if (count_reg < CAP) begin
            count_next = count_reg + jlp_pkg::COUNT_W'(1);
            if (ended_reg) begin
                ended_next = 1'b1;
            end else if (rx_byte == jlp_pkg::CHR_NUL) begin
                ended_next = 1'b1;
            end else begin
                x_num_next = x_step;
                y_num_next = y_step;
                if (x_seen_reg && (rx_byte == jlp_pkg::CHR_COMMA)) begin
                    comma_next = 1'b1;
                end
                if (rx_byte == jlp_pkg::CHR_COLON) begin
                    if ((prev_reg == jlp_pkg::CHR_X) && !x_seen_reg) begin
                        x_seen_next      = 1'b1;
                        x_num_next.phase = jlp_pkg::PH_LEAD;
                    end else if ((prev_reg == jlp_pkg::CHR_Y) && !y_seen_reg) begin
                        y_seen_next      = 1'b1;
                        fail_next        = fail_reg || !comma_reg;
                        y_num_next.phase = jlp_pkg::PH_LEAD;
                    end
                end
                prev_next = rx_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            prev_reg   <= '0;
            ended_reg  <= 1'b0;
            x_seen_reg <= 1'b0;
            comma_reg  <= 1'b0;
            y_seen_reg <= 1'b0;
            fail_reg   <= 1'b0;
            x_num_reg  <= NUM_CLEAR;
            y_num_reg  <= NUM_CLEAR;
        end else if (step_en) begin
            count_reg  <= count_next;
            prev_reg   <= prev_next;
            ended_reg  <= ended_next;
            x_seen_reg <= x_seen_next;
            comma_reg  <= comma_next;
            y_seen_reg <= y_seen_next;
            fail_reg   <= fail_next;
            x_num_reg  <= x_num_next;
            y_num_reg  <= y_num_next;
        end
    end

endmodule

>>> sv/joystick_line_parser_unit.sv
// Joystick line parser top level: input register, line core, clamp and result register.
//
// Usage:
//   s_valid/s_ready/s_rx_byte carry received serial bytes, one item per byte.
//   m_valid/m_ready/m_axis_x/m_axis_y carry one item per accepted text line:
//   the X and Y values, clamped to +/- clamp_limit, in two's complement.
//   cfg_valid/cfg_ready/cfg_clamp_limit write the clamp limit; cfg_ready is
//   always high. Write it only while the block is idle.
// Path: a byte sits in the input register and is parsed into the line state
//   when it advances; the line-ending byte that completes a valid line has
//   its result registered in the result register, which drives m_*.
// Throughput: one byte per cycle while no result waits with m_ready low; the next
//   line state is computed combinationally from the input register.
// Reset: clears the line state, empties both registers and sets the clamp
//   limit to 100.
// Stall: while a result waits with m_ready low, the input register holds its
//   byte, whatever it is, and once it holds one s_ready stays low until the result is taken.
module joystick_line_parser_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_rx_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [jlp_pkg::MAG_W-1:0] m_axis_x,
    output logic signed [jlp_pkg::MAG_W-1:0] m_axis_y,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [jlp_pkg::LIMIT_W-1:0]  cfg_clamp_limit
);

    logic                         in_valid_reg;
    logic [7:0]                   in_byte_reg;
    logic                         out_valid_reg;
    logic [jlp_pkg::MAG_W-1:0]    out_x_reg;
    logic [jlp_pkg::MAG_W-1:0]    out_y_reg;
    logic [jlp_pkg::LIMIT_W-1:0]  limit_reg;
    logic                         advance;
    jlp_pkg::line_result_t        result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    jlp_line_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= jlp_pkg::CLAMP_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (result.hit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                limit_reg <= cfg_clamp_limit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (result.hit) begin
            out_x_reg <= jlp_pkg::clamp_axis(result.x_negative, result.x_magnitude, limit_reg);
            out_y_reg <= jlp_pkg::clamp_axis(result.y_negative, result.y_magnitude, limit_reg);
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_axis_x = out_x_reg;
    assign m_axis_y = out_y_reg;

endmodule

>>> test/joystick_axis_checker.sv
// Line parser checker: predicts axis pairs from accepted bytes and compares each result.
module joystick_axis_checker
    import jlp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [7:0]              s_rx_byte,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [MAG_W-1:0] m_axis_x,
    input  logic signed [MAG_W-1:0] m_axis_y,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [LIMIT_W-1:0]      cfg_clamp_limit,
    output int                      mismatch_count,
    output int                      pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [MAG_W-1:0] x;
        logic signed [MAG_W-1:0] y;
    } axis_pair_t;

    axis_pair_t         pending_axes[$];
    int                 error_total;
    logic [LIMIT_W-1:0] clamp_lim;
    logic [COUNT_W-1:0] line_len;
    logic [7:0]         last_char;
    logic               text_done;
    logic               x_found;
    logic               comma_found;
    logic               y_found;
    logic               order_bad;
    num_state_t         x_num;
    num_state_t         y_num;

    function automatic void clear_line();
        line_len    = '0;
        last_char   = CHR_NUL;
        text_done   = 1'b0;
        x_found     = 1'b0;
        comma_found = 1'b0;
        y_found     = 1'b0;
        order_bad   = 1'b0;
        x_num       = '{phase: PH_IDLE, negative: 1'b0, magnitude: '0};
        y_num       = '{phase: PH_IDLE, negative: 1'b0, magnitude: '0};
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR);
    endfunction

    function automatic num_state_t number_next(num_state_t n, logic [7:0] c);
        int unsigned acc;
        if (n.phase == PH_LEAD) begin
            if (is_blank(c))
                return n;
            if (c == CHR_PLUS || c == CHR_MINUS) begin
                n.negative = (c == CHR_MINUS);
                n.phase = PH_DIGITS;
                return n;
            end
            n.phase = PH_DIGITS;
        end
        if (n.phase == PH_DIGITS) begin
            if (c >= CHR_ZERO && c <= CHR_NINE) begin
                acc = 32'(n.magnitude) * 10 + 32'(c - CHR_ZERO);
                n.magnitude = (acc > 32'hFFFF) ? 16'hFFFF : acc[MAG_W-1:0];
            end else begin
                n.phase = PH_DONE;
            end
        end
        return n;
    endfunction

    function automatic logic signed [MAG_W-1:0] clamp_to_limit(logic neg,
                                                               logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] capped;
        capped = (mag > {1'b0, clamp_lim}) ? {1'b0, clamp_lim} : mag;
        return neg ? (MAG_W'(0) - capped) : capped;
    endfunction

    task automatic parse_char(input logic [7:0] c);
        axis_pair_t pair;
        if (c == CHR_LF || c == CHR_CR) begin
            if (line_len != 0 && x_found && y_found && !order_bad) begin
                pair.x = clamp_to_limit(x_num.negative, x_num.magnitude);
                pair.y = clamp_to_limit(y_num.negative, y_num.magnitude);
                pending_axes.push_back(pair);
            end
            clear_line();
        end else if (line_len < LINE_CAPACITY) begin
            line_len++;
            if (!text_done) begin
                if (c == CHR_NUL) begin
                    text_done = 1'b1;
                end else begin
                    if (x_num.phase == PH_LEAD || x_num.phase == PH_DIGITS)
                        x_num = number_next(x_num, c);
                    if (y_num.phase == PH_LEAD || y_num.phase == PH_DIGITS)
                        y_num = number_next(y_num, c);
                    if (x_found && c == CHR_COMMA)
                        comma_found = 1'b1;
                    if (c == CHR_COLON) begin
                        if (last_char == CHR_X && !x_found) begin
                            x_found = 1'b1;
                            x_num.phase = PH_LEAD;
                        end else if (last_char == CHR_Y && !y_found) begin
                            y_found = 1'b1;
                            if (!comma_found)
                                order_bad = 1'b1;
                            y_num.phase = PH_LEAD;
                        end
                    end
                    last_char = c;
                end
            end
        end
    endtask

    task automatic note_error(input string msg);
        error_total++;
        if (error_total <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        axis_pair_t want;
        if (!aresetn) begin
            clamp_lim = CLAMP_RESET;
            clear_line();
            pending_axes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_axes.size() == 0) begin
                    note_error($sformatf("unexpected item: axis_x %0d axis_y %0d",
                                         m_axis_x, m_axis_y));
                end else begin
                    want = pending_axes.pop_front();
                    if (m_axis_x !== want.x)
                        note_error($sformatf("axis_x mismatch: expected %0d, got %0d",
                                             want.x, m_axis_x));
                    if (m_axis_y !== want.y)
                        note_error($sformatf("axis_y mismatch: expected %0d, got %0d",
                                             want.y, m_axis_y));
                end
            end
            if (cfg_valid && cfg_ready)
                clamp_lim = cfg_clamp_limit;
            if (s_valid && s_ready)
                parse_char(s_rx_byte);
        end
        mismatch_count <= error_total;
        pending_count  <= pending_axes.size();
    end

endmodule

>>> test/tb_joystick_line_parser_unit.sv
// Testbench top for the joystick line parser: stimulus, handshake pacing and verdict.
module tb_joystick_line_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import jlp_pkg::*;

    localparam logic [7:0] CHR_VT    = 8'h0B;
    localparam logic [7:0] CHR_FF    = 8'h0C;
    localparam logic [7:0] CHR_TILDE = 8'h7E;
    localparam int HOLD_CYCLES   = 300;
    localparam int SEGMENT_ITEMS = 190;
    localparam int SEGMENTS      = 6;
    localparam int SETTLE_CYCLES = 6;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_rx_byte = 8'h00;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [MAG_W-1:0] m_axis_x;
    logic signed [MAG_W-1:0] m_axis_y;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [LIMIT_W-1:0]      cfg_clamp_limit = '0;

    int         mismatch_count;
    int         pending_count;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         item_count = 0;
    int         hold_ticket = 0;
    int         hold_done = 0;
    logic [7:0] line_buf[$];

    joystick_line_parser_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_axis_x        (m_axis_x),
        .m_axis_y        (m_axis_y),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_clamp_limit (cfg_clamp_limit)
    );

    joystick_axis_checker axis_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_axis_x        (m_axis_x),
        .m_axis_y        (m_axis_y),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_clamp_limit (cfg_clamp_limit),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_done != hold_ticket) begin
                m_ready <= 1'b0;
                for (int i = 1; i < HOLD_CYCLES; i++)
                    @(posedge aclk);
                hold_done++;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        item_count++;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_item(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_idle();
        cfg_valid       <= 1'b1;
        cfg_clamp_limit <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic add_junk(input int most);
        repeat ($urandom_range(0, most))
            line_buf.push_back(8'($urandom_range(CHR_SPACE, CHR_TILDE)));
    endtask

    task automatic add_number();
        int digits;
        int pick;
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: line_buf.push_back(CHR_SPACE);
                1: line_buf.push_back(CHR_TAB);
                2: line_buf.push_back(CHR_VT);
                default: line_buf.push_back(CHR_FF);
            endcase
        end
        case ($urandom_range(0, 3))
            0: line_buf.push_back(CHR_MINUS);
            1: line_buf.push_back(CHR_PLUS);
            default: ;
        endcase
        pick = $urandom_range(0, 9);
        if (pick == 0)
            digits = 0;
        else if (pick < 8)
            digits = $urandom_range(1, 4);
        else
            digits = $urandom_range(5, 7);
        repeat (digits)
            line_buf.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_axis(input logic [7:0] mark);
        line_buf.push_back(mark);
        line_buf.push_back(CHR_COLON);
        add_number();
    endtask

    task automatic build_line();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            add_junk(2);
            add_axis(CHR_X);
            add_junk(1);
            line_buf.push_back(CHR_COMMA);
            add_junk(2);
            add_axis(CHR_Y);
            add_junk(2);
        end else if (pick < 66) begin
            add_axis(CHR_Y);
            line_buf.push_back(CHR_COMMA);
            add_axis(CHR_X);
        end else if (pick < 72) begin
            add_axis(CHR_X);
            add_junk(2);
            add_axis(CHR_Y);
        end else if (pick < 77) begin
            add_axis(CHR_X);
            line_buf.push_back(CHR_COMMA);
            if ($urandom_range(0, 1)) begin
                line_buf.push_back(CHR_NUL);
                add_axis(CHR_Y);
            end else begin
                add_axis(CHR_Y);
                line_buf.push_back(CHR_NUL);
                add_junk(3);
            end
        end else if (pick < 83) begin
            add_axis(CHR_X);
            line_buf.push_back(CHR_COMMA);
            repeat ($urandom_range(30, 55))
                line_buf.push_back(8'($urandom_range(CHR_SPACE, CHR_TILDE)));
            add_axis(CHR_Y);
        end else if (pick < 88) begin
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 20))
                line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_axis(CHR_X);
        end
        case ($urandom_range(0, 2))
            0: line_buf.push_back(CHR_CR);
            1: line_buf.push_back(CHR_LF);
            default: begin
                line_buf.push_back(CHR_CR);
                line_buf.push_back(CHR_LF);
            end
        endcase
    endtask

    initial begin
        int target;
        logic [LIMIT_W-1:0] limit;
        send_idle_pct = 20;
        recv_idle_pct = 87;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        add_text("X: -,Y:\t123");
        line_buf.push_back(CHR_CR);
        line_buf.push_back(CHR_LF);
        add_text("X:99999,Y:");
        line_buf.push_back(CHR_NUL);
        line_buf.push_back(CHR_LF);
        send_line();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 2) begin
                send_idle_pct = 87;
                recv_idle_pct = 20;
            end else if (seg == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg)
                0: limit = 15'h7FFF;
                1: limit = '0;
                2: limit = LIMIT_W'($urandom_range(1, 32766));
                3: limit = LIMIT_W'(1);
                4: limit = LIMIT_W'($urandom_range(2, 500));
                default: limit = 15'h7FFF;
            endcase
            write_limit(limit);
            // hold the result side while lines keep arriving
            if (seg == 4)
                hold_ticket <= hold_ticket + 1;
            target = item_count + SEGMENT_ITEMS;
            while (item_count < target) begin
                build_line();
                send_line();
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> joystick_line_parser_unit.f
sv/jlp_pkg.sv
sv/jlp_num_unit.sv
sv/jlp_line_core.sv
sv/joystick_line_parser_unit.sv
test/joystick_axis_checker.sv
test/tb_joystick_line_parser_unit.sv
